// ===== design/wcag_pkg.sv =====
// ----------------------------------------------------------------------------
// wcag_pkg
// Shared types, constants and the elaboration-time sRGB linearization
// function for the readable text color selector.
// ----------------------------------------------------------------------------
package wcag_pkg;

	localparam int LINEAR_BITS_DEF = 16;
	localparam int RGB_W = 24;
	localparam int CFG_W = 12;
	localparam int REM_W = 14;
	localparam int RSUM_W = 16;

	localparam logic [CFG_W-1:0] MIN_CONTRAST_RST = 12'd450;
	localparam logic [RGB_W-1:0] WHITE_RGB = 24'hFFFFFF;
	localparam logic [RGB_W-1:0] BLACK_RGB = 24'h000000;

	localparam longint W_RED = 2126;
	localparam longint W_GREEN = 7152;
	localparam longint W_BLUE = 722;
	localparam longint LUMA_DIV = 10000;

	localparam logic [RSUM_W-1:0] RSUM_HALF = 16'd5000;
	localparam logic [RSUM_W-1:0] RSUM_ONE = 16'd10000;
	localparam logic [RSUM_W-1:0] RSUM_TWO = 16'd20000;
	localparam logic [RSUM_W-1:0] RSUM_THREE = 16'd30000;

	localparam logic [6:0] RATIO_SCALE = 7'd100;

	typedef struct packed {
		logic [RGB_W-1:0] desired_rgb;
		logic [RGB_W-1:0] background_rgb;
	} pair_t;

	typedef struct packed {
		logic [RGB_W-1:0] result_rgb;
		logic used_fallback;
	} pick_t;

	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic vld_s2;
	} luma_ctl_t;

	// Linearized channel value in Q1.b, rounded to nearest. Evaluated only
	// at elaboration; the power curve is resolved by an exact integer search.
	function automatic logic [31:0] lin_value(input int v, input int b);
		logic [383:0] rhs;
		logic [383:0] den12;
		logic [383:0] lhs;
		logic [383:0] num;
		logic [383:0] den;
		logic [63:0] t;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] mid;
		logic [31:0] odd;
		if (v <= 10) begin
			t = ((64'(v) * 64'd50) << b) + 64'd82365;
			return 32'(t / 64'd164730);
		end
		num = 384'(1000 * v + 14025);
		den = 384'd269025;
		rhs = 384'd1;
		den12 = 384'd1;
		for (int i = 0; i < 12; i++) begin
			rhs = rhs * num;
			den12 = den12 * den;
		end
		rhs = rhs << (5 * b + 5);
		lo = 32'd0;
		hi = (32'd1 << b) + 32'd1;
		while (hi - lo > 32'd1) begin
			mid = lo + ((hi - lo) >> 1);
			odd = 32'd2 * mid - 32'd1;
			lhs = den12;
			for (int k = 0; k < 5; k++) begin
				lhs = lhs * 384'(odd);
			end
			if (lhs <= rhs) begin
				lo = mid;
			end else begin
				hi = mid;
			end
		end
		return lo;
	endfunction

endpackage

// ===== design/wcag_luma.sv =====
// ----------------------------------------------------------------------------
// wcag_luma
// Two-stage relative luminance of one 8-bit RGB color: table lookup of the
// weighted linear channels, then the sum with rounding to Q1.B.
// ----------------------------------------------------------------------------
module wcag_luma #(
	parameter int LINEAR_BITS = wcag_pkg::LINEAR_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  wcag_pkg::luma_ctl_t ctl,
	input  logic [wcag_pkg::RGB_W-1:0] rgb,
	output logic [LINEAR_BITS:0] lum
);
	import wcag_pkg::*;

	localparam int LB = LINEAR_BITS;
	localparam logic [LB:0] LUM_WHITE = (LB + 1)'(1) << LB;

	logic [LB-1:0] quot_r [256];
	logic [LB-1:0] quot_g [256];
	logic [LB-1:0] quot_b [256];
	logic [REM_W-1:0] rem_r [256];
	logic [REM_W-1:0] rem_g [256];
	logic [REM_W-1:0] rem_b [256];

	for (genvar i = 0; i < 256; i++) begin : g_lut
		localparam logic [31:0] LIN = lin_value(i, LB);
		localparam longint PR = W_RED * longint'(LIN);
		localparam longint PG = W_GREEN * longint'(LIN);
		localparam longint PB = W_BLUE * longint'(LIN);
		localparam longint QR = PR / LUMA_DIV;
		localparam longint QG = PG / LUMA_DIV;
		localparam longint QB = PB / LUMA_DIV;
		localparam longint RR = PR % LUMA_DIV;
		localparam longint RG = PG % LUMA_DIV;
		localparam longint RB = PB % LUMA_DIV;
		assign quot_r[i] = LB'(QR);
		assign quot_g[i] = LB'(QG);
		assign quot_b[i] = LB'(QB);
		assign rem_r[i] = REM_W'(RR);
		assign rem_g[i] = REM_W'(RG);
		assign rem_b[i] = REM_W'(RB);
	end

	logic [LB-1:0] q_r_s1;
	logic [LB-1:0] q_g_s1;
	logic [LB-1:0] q_b_s1;
	logic [RSUM_W-1:0] rsum_s1;
	logic [LB:0] lum_s2;
	logic [1:0] carry;

	always_ff @(posedge clk) begin
		if (ctl.ld_s1) begin
			q_r_s1 <= quot_r[rgb[23:16]];
			q_g_s1 <= quot_g[rgb[15:8]];
			q_b_s1 <= quot_b[rgb[7:0]];
			rsum_s1 <= RSUM_W'(rem_r[rgb[23:16]]) + RSUM_W'(rem_g[rgb[15:8]])
				+ RSUM_W'(rem_b[rgb[7:0]]) + RSUM_HALF;
		end
	end

	always_comb begin
		if (rsum_s1 >= RSUM_THREE) begin
			carry = 2'd3;
		end else if (rsum_s1 >= RSUM_TWO) begin
			carry = 2'd2;
		end else if (rsum_s1 >= RSUM_ONE) begin
			carry = 2'd1;
		end else begin
			carry = 2'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			lum_s2 <= (LB + 1)'(q_r_s1) + (LB + 1)'(q_g_s1) + (LB + 1)'(q_b_s1)
				+ (LB + 1)'(carry);
		end
	end

	assign lum = lum_s2;

	// A luminance never exceeds that of white.
	a_lum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.vld_s2 |-> lum_s2 <= LUM_WHITE)
		else $error("luminance above full scale");

endmodule

// ===== design/wcag_contrast_text_color_select_core.sv =====
// ----------------------------------------------------------------------------
// wcag_contrast_text_color_select_core
// Readable text color selection by contrast ratio against a background.
// ----------------------------------------------------------------------------
// The block takes one color pair per clock while the output is not stalled
// and returns one item per pair through a table lookup stage, a luminance
// sum stage, a multiply stage for the cross-multiplied ratio tests, and the
// output register. The linearization tables are constants built at
// elaboration, so there is no memory and no clearing pass after reset. A
// stalled output holds only the stages behind it that are full; empty stages
// keep taking pairs. The threshold register is written through the cfg port,
// which is always ready, and should change only while no item is in flight.
module wcag_contrast_text_color_select_core #(
	parameter int LINEAR_BITS = wcag_pkg::LINEAR_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic pair_valid,
	output logic pair_stall,
	input  wcag_pkg::pair_t pair,
	output logic pick_valid,
	input  logic pick_stall,
	output wcag_pkg::pick_t pick,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [wcag_pkg::CFG_W-1:0] cfg_data
);
	import wcag_pkg::*;

	localparam int LB = LINEAR_BITS;
	localparam int PW = LB + 1;
	localparam int CW = PW + CFG_W;
	localparam int SW = 2 * PW;
	localparam longint OFF_VAL = ((longint'(1) << LB) + 10) / 20;
	localparam longint WHITE_VAL = (longint'(1) << LB) + OFF_VAL;
	localparam longint WPROD_VAL = WHITE_VAL * OFF_VAL;
	localparam logic [PW-1:0] OFFSET = PW'(OFF_VAL);
	localparam logic [SW-1:0] WHITE_PROD = SW'(WPROD_VAL);

	logic [CFG_W-1:0] min_contrast_q;
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	luma_ctl_t ctl;
	logic [PW-1:0] lum_d;
	logic [PW-1:0] lum_b;
	logic [RGB_W-1:0] rgb_s1, rgb_s2, rgb_s3;
	logic [PW-1:0] hi_p, lo_q, bg_q;
	logic [CW-1:0] num_s3, den_s3;
	logic [SW-1:0] sq_s3;
	pick_t pick_s4;
	logic pass, white_wins;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_contrast_q <= MIN_CONTRAST_RST;
		end else if (cfg_valid && cfg_ready) begin
			min_contrast_q <= cfg_data;
		end
	end

	assign rdy4 = !vld_s4 || !pick_stall;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;
	assign pair_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy1) begin
				vld_s1 <= pair_valid;
			end
			if (rdy2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy3) begin
				vld_s3 <= vld_s2;
			end
			if (rdy4) begin
				vld_s4 <= vld_s3;
			end
		end
	end

	assign ctl.ld_s1 = rdy1;
	assign ctl.ld_s2 = rdy2;
	assign ctl.vld_s2 = vld_s2;

	wcag_luma #(.LINEAR_BITS(LINEAR_BITS)) u_luma_desired (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.rgb(pair.desired_rgb),
		.lum(lum_d)
	);

	wcag_luma #(.LINEAR_BITS(LINEAR_BITS)) u_luma_background (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.rgb(pair.background_rgb),
		.lum(lum_b)
	);

	always_ff @(posedge clk) begin
		if (rdy1) begin
			rgb_s1 <= pair.desired_rgb;
		end
		if (rdy2) begin
			rgb_s2 <= rgb_s1;
		end
	end

	always_comb begin
		if (lum_d > lum_b) begin
			hi_p = lum_d + OFFSET;
			lo_q = lum_b + OFFSET;
		end else begin
			hi_p = lum_b + OFFSET;
			lo_q = lum_d + OFFSET;
		end
		bg_q = lum_b + OFFSET;
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			rgb_s3 <= rgb_s2;
			num_s3 <= CW'(hi_p) * CW'(RATIO_SCALE);
			den_s3 <= CW'(min_contrast_q) * CW'(lo_q);
			sq_s3 <= SW'(bg_q) * SW'(bg_q);
		end
	end

	assign pass = num_s3 >= den_s3;
	assign white_wins = WHITE_PROD >= sq_s3;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			pick_s4.used_fallback <= !pass;
			if (pass) begin
				pick_s4.result_rgb <= rgb_s3;
			end else if (white_wins) begin
				pick_s4.result_rgb <= WHITE_RGB;
			end else begin
				pick_s4.result_rgb <= BLACK_RGB;
			end
		end
	end

	assign pick = pick_s4;
	assign pick_valid = vld_s4;

	// A replaced color is always pure white or pure black.
	a_fallback_bw: assert property (@(posedge clk) disable iff (!arst_n)
		pick_valid && pick.used_fallback |->
		pick.result_rgb == WHITE_RGB || pick.result_rgb == BLACK_RGB)
		else $error("fallback color is neither white nor black");

	// An item in the multiply stage moves on whenever the output can take it.
	a_stage_advance: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && rdy4 |=> vld_s4)
		else $error("item lost between multiply stage and output");

	// An empty luminance stage never holds back the input.
	a_bubble_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s2 |-> !pair_stall)
		else $error("input stalled while the pipeline has room");

endmodule
